@@ hdl/fixed_point_alu_unit_defines.svh @@
// Assertion macros for the fixed-point ALU.
`ifndef FIXED_POINT_ALU_UNIT_DEFINES_SVH
`define FIXED_POINT_ALU_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define FPA_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("fixed point alu check failed");
`define FPA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("fixed point alu check failed");
`else
`define FPA_ASSERT(lbl, clk, rst, prop)
`define FPA_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ hdl/fpa_pkg.sv @@
// Types, constants and action codes shared by the fixed-point ALU.
package fpa_pkg;

  localparam int FRAC_BITS = 8;
  localparam int WORD_BITS = 32;
  localparam int DATA_W    = 32;
  localparam int SAT_W     = (WORD_BITS < DATA_W) ? WORD_BITS : DATA_W;
  localparam int EXT_W     = 2 * DATA_W + 2;
  localparam int NUM_W     = DATA_W + FRAC_BITS;
  localparam int QB        = 2;
  localparam int DIV_STAGES = (NUM_W + QB - 1) / QB;
  localparam int NUM_PAD   = DIV_STAGES * QB;

  typedef enum logic [3:0] {
    ACT_ADD      = 4'd0,
    ACT_SUB      = 4'd1,
    ACT_MUL      = 4'd2,
    ACT_DIV      = 4'd3,
    ACT_GT       = 4'd4,
    ACT_LT       = 4'd5,
    ACT_GE       = 4'd6,
    ACT_LE       = 4'd7,
    ACT_EQ       = 4'd8,
    ACT_NE       = 4'd9,
    ACT_INC      = 4'd10,
    ACT_DEC      = 4'd11,
    ACT_MIN      = 4'd12,
    ACT_MAX      = 4'd13,
    ACT_TO_INT   = 4'd14,
    ACT_FROM_INT = 4'd15
  } action_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;

  localparam logic signed [EXT_W-1:0] SAT_HI = (EXT_W'(1) <<< (SAT_W - 1)) - EXT_W'(1);
  localparam logic signed [EXT_W-1:0] SAT_LO = -SAT_HI - EXT_W'(1);
  localparam logic [EXT_W-1:0] RND_ADD =
    (FRAC_BITS == 0) ? EXT_W'(0) : (EXT_W'(1) << ((FRAC_BITS > 0) ? FRAC_BITS - 1 : 0));

  typedef struct packed {
    logic [3:0]               action;
    logic signed [DATA_W-1:0] operand_a;
    logic signed [DATA_W-1:0] operand_b;
  } req_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic                     compare_true;
    logic [1:0]               status;
  } rsp_word_t;

  typedef struct packed {
    logic                    valid;
    action_t                 action;
    logic                    neg;
    logic                    zero_div;
    logic                    cmp;
    logic signed [EXT_W-1:0] pre;
    logic [DATA_W-1:0]       den;
    logic [DATA_W-1:0]       rem;
    logic [NUM_PAD-1:0]      quo;
  } pipe_t;

endpackage

@@ hdl/fpa_front.sv @@
// Operand decode, simple results, magnitudes and the multiplier (two stages).
module fpa_front import fpa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  req_word_t in_word,
  output pipe_t     out_pipe
);

  typedef struct packed {
    logic                    valid;
    action_t                 action;
    logic                    neg;
    logic                    zero_div;
    logic                    cmp;
    logic signed [EXT_W-1:0] pre;
    logic [DATA_W-1:0]       ma;
    logic [DATA_W-1:0]       mb;
  } mid_t;

  mid_t  s1, s1_next;
  pipe_t s2_next;

  logic signed [EXT_W-1:0] a, b;
  logic signed [EXT_W-1:0] neg_a, neg_b;
  logic [2*DATA_W-1:0]     prod;

  assign a     = EXT_W'(in_word.operand_a);
  assign b     = EXT_W'(in_word.operand_b);
  assign neg_a = -a;
  assign neg_b = -b;
  assign prod  = (2*DATA_W)'(s1.ma) * (2*DATA_W)'(s1.mb);

  always_comb begin
    s1_next          = '0;
    s1_next.valid    = in_valid;
    s1_next.action   = action_t'(in_word.action);
    s1_next.neg      = in_word.operand_a[DATA_W-1] ^ in_word.operand_b[DATA_W-1];
    s1_next.zero_div = (in_word.operand_b == '0);
    s1_next.ma       = in_word.operand_a[DATA_W-1] ? neg_a[DATA_W-1:0] : a[DATA_W-1:0];
    s1_next.mb       = in_word.operand_b[DATA_W-1] ? neg_b[DATA_W-1:0] : b[DATA_W-1:0];
    unique case (action_t'(in_word.action)) inside
      ACT_ADD:      s1_next.pre = a + b;
      ACT_SUB:      s1_next.pre = a - b;
      ACT_INC:      s1_next.pre = a + EXT_W'(1);
      ACT_DEC:      s1_next.pre = a - EXT_W'(1);
      ACT_MIN:      s1_next.pre = (a < b) ? a : b;
      ACT_MAX:      s1_next.pre = (a > b) ? a : b;
      ACT_TO_INT:   s1_next.pre = a >>> FRAC_BITS;
      ACT_FROM_INT: s1_next.pre = a <<< FRAC_BITS;
      ACT_GT:       s1_next.cmp = (a > b);
      ACT_LT:       s1_next.cmp = (a < b);
      ACT_GE:       s1_next.cmp = (a >= b);
      ACT_LE:       s1_next.cmp = (a <= b);
      ACT_EQ:       s1_next.cmp = (a == b);
      ACT_NE:       s1_next.cmp = (a != b);
      ACT_MUL, ACT_DIV: s1_next.pre = '0;
      default:      s1_next.pre = '0;
    endcase
  end

  always_comb begin
    s2_next          = '0;
    s2_next.valid    = s1.valid;
    s2_next.action   = s1.action;
    s2_next.neg      = s1.neg;
    s2_next.zero_div = s1.zero_div;
    s2_next.cmp      = s1.cmp;
    s2_next.pre      = (s1.action == ACT_MUL) ? EXT_W'(prod) : s1.pre;
    s2_next.den      = s1.mb;
    s2_next.rem      = '0;
    s2_next.quo      = NUM_PAD'(s1.ma) << FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1       <= '0;
      out_pipe <= '0;
    end else begin
      s1       <= s1_next;
      out_pipe <= s2_next;
    end
  end

endmodule

@@ hdl/fpa_div_stage.sv @@
// One restoring-division stage, QB quotient bits per stage.
module fpa_div_stage import fpa_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  pipe_t in_pipe,
  output pipe_t out_pipe
);

  pipe_t step_next;

  always_comb begin
    logic [DATA_W:0]    trial;
    logic [DATA_W-1:0]  r;
    logic [NUM_PAD-1:0] q;
    step_next = in_pipe;
    r = in_pipe.rem;
    q = in_pipe.quo;
    for (int i = 0; i < QB; i++) begin
      trial = {r, q[NUM_PAD-1]};
      q = {q[NUM_PAD-2:0], 1'b0};
      if (trial >= {1'b0, in_pipe.den}) begin
        trial = trial - {1'b0, in_pipe.den};
        q[0] = 1'b1;
      end
      r = trial[DATA_W-1:0];
    end
    step_next.rem = r;
    step_next.quo = q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_pipe <= '0;
    end else begin
      out_pipe <= step_next;
    end
  end

endmodule

@@ hdl/fpa_back.sv @@
// Rounding, sign, saturation and the output register.
module fpa_back import fpa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  pipe_t     in_pipe,
  output logic      done,
  output rsp_word_t result
);

  rsp_word_t result_next;
  logic signed [EXT_W-1:0] val, mag;
  logic round_up;

  assign round_up = ({in_pipe.rem, 1'b0} >= {1'b0, in_pipe.den});

  always_comb begin
    mag    = '0;
    val    = in_pipe.pre;
    result_next = '0;
    result_next.status = ST_OK;
    case (in_pipe.action)
      ACT_MUL: begin
        mag = (in_pipe.pre + RND_ADD) >>> FRAC_BITS;
        val = in_pipe.neg ? -mag : mag;
      end
      ACT_DIV: begin
        mag = EXT_W'(in_pipe.quo) + EXT_W'(round_up);
        val = in_pipe.neg ? -mag : mag;
      end
      default: val = in_pipe.pre;
    endcase
    if (in_pipe.action == ACT_DIV && in_pipe.zero_div) begin
      result_next.result_value = '0;
      result_next.status       = ST_DIV0;
    end else if (val > SAT_HI) begin
      result_next.result_value = SAT_HI[DATA_W-1:0];
      result_next.status       = ST_OVF;
    end else if (val < SAT_LO) begin
      result_next.result_value = SAT_LO[DATA_W-1:0];
      result_next.status       = ST_OVF;
    end else begin
      result_next.result_value = val[DATA_W-1:0];
    end
    result_next.compare_true = in_pipe.cmp;
  end

  always_ff @(posedge clk) begin
    result <= result_next;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_pipe.valid;
    end
  end

endmodule

@@ hdl/fixed_point_alu_unit.sv @@
// Top level of the pipelined Q24.8 fixed-point ALU.
//   channel   handshake           word
//   request   start / busy        action, operand_a, operand_b
//   result    done (one cycle)    result_value, compare_true, status
// A word is taken every cycle while busy is low; its result passes through the front stages,
// the DIV_STAGES divider stages and the output register, for every action alike.
// The divider resolves two quotient bits per stage.
// Synchronous reset empties the pipeline; busy is high only during reset.
// No stalls: results are shown for one cycle and must be taken.
`include "fixed_point_alu_unit_defines.svh"
module fixed_point_alu_unit import fpa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  req_word_t request,
  output logic      done,
  output rsp_word_t result
);

  pipe_t div_pipe [DIV_STAGES+1];

  assign busy = rst;

  fpa_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start & ~busy),
    .in_word  (request),
    .out_pipe (div_pipe[0])
  );

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    fpa_div_stage u_stage (
      .clk      (clk),
      .rst      (rst),
      .in_pipe  (div_pipe[g]),
      .out_pipe (div_pipe[g+1])
    );
  end

  fpa_back u_back (
    .clk     (clk),
    .rst     (rst),
    .in_pipe (div_pipe[DIV_STAGES]),
    .done    (done),
    .result  (result)
  );

  `FPA_ASSERT(a_div0_zero, clk, rst, (done && result.status == ST_DIV0) |-> (result.result_value == '0))
  `FPA_ASSERT(a_cmp_clean, clk, rst, (done && result.compare_true) |-> (result.result_value == '0 && result.status == ST_OK))
  `FPA_ASSERT(a_ovf_bound, clk, rst, (done && result.status == ST_OVF) |-> (result.result_value == SAT_HI[DATA_W-1:0] || result.result_value == SAT_LO[DATA_W-1:0]))
  `FPA_ASSERT_ALWAYS(a_busy_reset, clk, busy == rst)

endmodule

@@ tb/sv/testbench.sv @@
// Testbench for the Q24.8 fixed-point ALU: random and corner words checked against a predictor.
module testbench;
  import fpa_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  req_word_t request = '0;
  logic      done;
  rsp_word_t result;

  fixed_point_alu_unit uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .request(request), .done(done), .result(result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  req_word_t pending_words[$];
  rsp_word_t expected_results[$];
  int unsigned errors = 0;
  int unsigned results_seen = 0;
  int unsigned idle_cycles = 0;
  bit timed_out = 1'b0;
  bit no_gaps = 1'b0;
  bit drain_hold = 1'b0;
  int unsigned action_count[16];

  // busy as sampled at the last rising edge decides acceptance
  logic busy_q = 1'b1;

  localparam int LATENCY = DIV_STAGES + 3;
  localparam int WATCHDOG = 2000;

  function automatic longint sat_word(input longint v, inout logic [1:0] st);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (SAT_W - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      st = ST_OVF;
      return hi;
    end
    if (v < lo) begin
      st = ST_OVF;
      return lo;
    end
    return v;
  endfunction

  function automatic rsp_word_t alu_predict(input req_word_t w);
    rsp_word_t r;
    longint a;
    longint b;
    longint v;
    logic [1:0] st;
    bit neg;
    logic [127:0] m;
    logic [127:0] num;
    logic [127:0] den;
    logic [127:0] q;
    logic [127:0] rm;
    a = longint'(w.operand_a);
    b = longint'(w.operand_b);
    v = 0;
    st = ST_OK;
    r = '0;
    neg = (a < 0) != (b < 0);
    case (action_t'(w.action))
      ACT_ADD: v = sat_word(a + b, st);
      ACT_SUB: v = sat_word(a - b, st);
      ACT_MUL: begin
        m = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
        if (FRAC_BITS > 0) m = (m + (128'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        v = sat_word(neg ? -longint'(m) : longint'(m), st);
      end
      ACT_DIV: begin
        if (b == 0) begin
          st = ST_DIV0;
        end else begin
          num = 128'(a < 0 ? -a : a) << FRAC_BITS;
          den = 128'(b < 0 ? -b : b);
          q = num / den;
          rm = num % den;
          if (rm * 2 >= den) q = q + 1;
          v = sat_word(neg ? -longint'(q) : longint'(q), st);
        end
      end
      ACT_GT: r.compare_true = a > b;
      ACT_LT: r.compare_true = a < b;
      ACT_GE: r.compare_true = a >= b;
      ACT_LE: r.compare_true = a <= b;
      ACT_EQ: r.compare_true = a == b;
      ACT_NE: r.compare_true = a != b;
      ACT_INC: v = sat_word(a + 1, st);
      ACT_DEC: v = sat_word(a - 1, st);
      ACT_MIN: v = sat_word(a < b ? a : b, st);
      ACT_MAX: v = sat_word(a > b ? a : b, st);
      ACT_TO_INT: v = sat_word(a >>> FRAC_BITS, st);
      default: v = sat_word(a * (longint'(1) <<< FRAC_BITS), st);
    endcase
    r.result_value = v[DATA_W-1:0];
    r.status = st;
    return r;
  endfunction

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000 + $urandom_range(0, 3);
      1: return 32'h7fff_ffff - $urandom_range(0, 3);
      2: return 32'($signed($urandom_range(0, 1024)) - 512);
      3: return 32'(($urandom_range(0, 600) - 300) <<< FRAC_BITS);
      4: return 32'($signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000);
      5: return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic req_word_t mk(input action_t act, input logic [31:0] a,
                                    input logic [31:0] b);
    req_word_t w;
    w.action = act;
    w.operand_a = a;
    w.operand_b = b;
    return w;
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst && start && !busy_q) begin
      void'(pending_words.pop_front());
    end
    if (!rst && pending_words.size() > 0 && !drain_hold &&
        (no_gaps || $urandom_range(0, 99) >= 27)) begin
      start <= 1'b1;
      request <= pending_words[0];
    end else begin
      start <= 1'b0;
      request <= '0;
    end
  end

  always @(posedge clk) begin
    busy_q <= busy;
    if (!rst && start && !busy) begin
      expected_results.push_back(alu_predict(request));
      action_count[request.action]++;
    end
  end

  // monitor
  always @(posedge clk) begin
    rsp_word_t exp_r;
    if (!rst && done) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, result);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (result.result_value !== exp_r.result_value)
          $display("%0t: result_value expected %h actual %h", $time,
                   exp_r.result_value, result.result_value);
        if (result.compare_true !== exp_r.compare_true)
          $display("%0t: compare_true expected %b actual %b", $time,
                   exp_r.compare_true, result.compare_true);
        if (result.status !== exp_r.status)
          $display("%0t: status expected %0d actual %0d", $time,
                   exp_r.status, result.status);
        if (result !== exp_r) errors++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [31:0] a;
    logic [31:0] b;
    int unsigned min_count;
    for (int i = 0; i < 16; i++) action_count[i] = 0;
    // directed corners
    for (int i = 0; i < 16; i++)
      pending_words.push_back(mk(action_t'(i), 32'h7fff_ffff, 32'h8000_0000));
    pending_words.push_back(mk(ACT_DIV, 32'h0000_0100, 32'h0));
    pending_words.push_back(mk(ACT_DIV, 32'h8000_0000, 32'h0000_0001));
    pending_words.push_back(mk(ACT_MUL, 32'h0000_0180, 32'hffff_ff80));
    pending_words.push_back(mk(ACT_MIN, 32'h0000_0005, 32'h0000_0005));
    pending_words.push_back(mk(ACT_MAX, 32'hffff_fff0, 32'hffff_fff0));
    pending_words.push_back(mk(ACT_TO_INT, 32'hffff_ff01, 32'h0));
    pending_words.push_back(mk(ACT_EQ, 32'hffff_ffff, 32'hffff_ffff));
    pending_words.push_back(mk(ACT_DEC, 32'h8000_0000, 32'hffff_ffff));
    pending_words.push_back(mk(ACT_INC, 32'h7fff_ffff, 32'h0));
    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    wait (pending_words.size() == 0);
    // hold off until the pipeline drains
    drain_hold = 1'b1;
    wait (expected_results.size() == 0);
    drain_hold = 1'b0;
    for (int i = 0; i < 850; i++) begin
      a = pick_operand();
      b = ($urandom_range(0, 19) == 0) ? 32'h0 : pick_operand();
      pending_words.push_back(mk(action_t'($urandom_range(0, 15)), a, b));
      if (i == 300) no_gaps = 1'b1;
      if (i == 450) no_gaps = 1'b0;
      if (pending_words.size() > 40) wait (pending_words.size() < 10);
    end
    wait (pending_words.size() == 0);
    wait (expected_results.size() == 0);
    repeat (LATENCY + 5) @(posedge clk);
    min_count = action_count[0];
    for (int i = 1; i < 16; i++)
      if (action_count[i] < min_count) min_count = action_count[i];
    $display("Checked %0d results across all 16 actions (min per action %0d).",
             results_seen, min_count);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
